// ===== src/aabb_pkg.sv =====
package aabb_pkg;

	// scan sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_PICK,
		ST_FLUSH
	} scan_state_t;

	// side of least penetration
	typedef enum logic [1:0] {
		SIDE_TOP    = 2'd0,
		SIDE_BOTTOM = 2'd1,
		SIDE_LEFT   = 2'd2,
		SIDE_RIGHT  = 2'd3
	} side_t;

	// classification of one box, carried from the front to the back
	typedef struct packed {
		logic final_box;
		logic store;
		logic dropped;
	} box_ctl_t;

	localparam int INDEX_OUT_W = 3;
	localparam int DEPTH_W = 16;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;

endpackage

// ===== src/aabb_pairwise_collision.sv =====
// pairwise overlap test of axis-aligned boxes
//
// input channel (in_valid / in_ready): one box per transfer, signed corners
// min_x, min_y, max_x, max_y and final_box marking the last box of a frame.
// output channel (out_valid / out_ready): one item per overlapping pair,
// in load order of (first, second), or one item with pair_valid 0 when no
// pair overlaps; run_end marks the last item of the frame.
// boxes pass a two-entry queue into the store; each plain box is written
// through the store's one write port. after the final box the scan takes
// each pair through three steps (register the two rows, compare and
// subtract, pick the least depth), MAX_BOXES*(MAX_BOXES-1)/2 pairs at most,
// and the output register then hands out the last item.
// a hit is held until a later hit or the flush, so run_end can mark the last.
// boxes of the next frame keep being taken until the queue is full.
// a stalled receiver holds the output register; the scan stops on the next
// hit until the register frees, and the queue backs up to in_ready.
// reset empties the queue, the store count and the drop flag.
module aabb_pairwise_collision #(
	parameter int MAX_BOXES  = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        min_x,
	input  logic signed [COORD_BITS-1:0]        min_y,
	input  logic signed [COORD_BITS-1:0]        max_x,
	input  logic signed [COORD_BITS-1:0]        max_y,
	input  logic                                final_box,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pair_valid,
	output logic [aabb_pkg::INDEX_OUT_W-1:0]    first_index,
	output logic [aabb_pkg::INDEX_OUT_W-1:0]    second_index,
	output logic [aabb_pkg::DEPTH_W-1:0]        overlap_depth,
	output logic [1:0]                          contact_side,
	output logic                                boxes_dropped,
	output logic                                run_end
);
	import aabb_pkg::*;

	localparam int IDX_W  = $clog2(MAX_BOXES);
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int BOX_W  = 4 * COORD_BITS;
	localparam int CTL_W  = $bits(box_ctl_t);
	localparam int ITEM_W = CTL_W + IDX_W + CNT_W + BOX_W;

	logic             f_valid;
	logic             f_ready;
	box_ctl_t         f_ctl;
	logic [IDX_W-1:0] f_slot;
	logic [CNT_W-1:0] f_count;
	logic [BOX_W-1:0] f_box;
	logic             q_valid;
	logic             q_ready;
	logic [ITEM_W-1:0] q_data;
	box_ctl_t         q_ctl;
	logic [IDX_W-1:0] q_slot;
	logic [CNT_W-1:0] q_count;
	logic [BOX_W-1:0] q_box;

	// classify and count incoming boxes
	aabb_front #(
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.min_x     (min_x),
		.min_y     (min_y),
		.max_x     (max_x),
		.max_y     (max_y),
		.final_box (final_box),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd_ctl   (f_ctl),
		.cmd_slot  (f_slot),
		.cmd_count (f_count),
		.cmd_box   (f_box)
	);

	// queue between front and back
	aabb_fifo #(
		.WIDTH (ITEM_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  ({f_ctl, f_slot, f_count, f_box}),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	assign {q_ctl, q_slot, q_count, q_box} = q_data;

	// store, pair scan and result output
	aabb_back #(
		.MAX_BOXES  (MAX_BOXES),
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (q_valid),
		.cmd_ready     (q_ready),
		.cmd_ctl       (q_ctl),
		.cmd_slot      (q_slot),
		.cmd_count     (q_count),
		.cmd_box       (q_box),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pair_valid    (pair_valid),
		.first_index   (first_index),
		.second_index  (second_index),
		.overlap_depth (overlap_depth),
		.contact_side  (contact_side),
		.boxes_dropped (boxes_dropped),
		.run_end       (run_end)
	);

	// pairs are reported with the first index below the second
	assert property (@(posedge clk) disable iff (!arst_n)
		(MAX_BOXES <= 8) && out_valid && pair_valid |-> second_index > first_index)
		else $error("pair indices out of order");

	// an empty scan result is the frame's only and last item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pair_valid |-> run_end && overlap_depth == '0 &&
		first_index == '0 && second_index == '0)
		else $error("malformed no-pair item");

	// input back-pressure only comes from a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_valid)
		else $error("input stalled with an empty queue");

	// a box leaves the queue only while the back is idle
	assert property (@(posedge clk) disable iff (!arst_n)
		q_valid && q_ready && q_ctl.final_box |=> !q_ready)
		else $error("back took a box during a scan");

endmodule

// ===== src/aabb_front.sv =====
module aabb_front #(
	parameter int MAX_BOXES  = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        min_x,
	input  logic signed [COORD_BITS-1:0]        min_y,
	input  logic signed [COORD_BITS-1:0]        max_x,
	input  logic signed [COORD_BITS-1:0]        max_y,
	input  logic                                final_box,
	output logic                                cmd_valid,
	input  logic                                cmd_ready,
	output aabb_pkg::box_ctl_t                  cmd_ctl,
	output logic [$clog2(MAX_BOXES)-1:0]        cmd_slot,
	output logic [$clog2(MAX_BOXES+1)-1:0]      cmd_count,
	output logic [4*COORD_BITS-1:0]             cmd_box
);
	import aabb_pkg::*;

	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);

	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             accept;
	logic             has_room;

	// transfer into the queue whenever it has space
	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	// classify: store at the next slot, or drop when full
	assign has_room          = count_q < CNT_W'(MAX_BOXES);
	assign cmd_ctl.final_box = final_box;
	assign cmd_ctl.store     = has_room;
	assign cmd_ctl.dropped   = overflow_q || !has_room;
	assign cmd_slot          = count_q[IDX_W-1:0];
	assign cmd_count         = has_room ? count_q + CNT_W'(1) : count_q;
	assign cmd_box           = {min_x, min_y, max_x, max_y};

	// frame fill count and drop flag, cleared by the final box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			if (final_box) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				count_q    <= cmd_count;
				overflow_q <= cmd_ctl.dropped;
			end
		end
	end

endmodule

// ===== src/aabb_fifo.sv =====
module aabb_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// two-entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== src/aabb_back.sv =====
module aabb_back #(
	parameter int MAX_BOXES  = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  aabb_pkg::box_ctl_t                  cmd_ctl,
	input  logic [$clog2(MAX_BOXES)-1:0]        cmd_slot,
	input  logic [$clog2(MAX_BOXES+1)-1:0]      cmd_count,
	input  logic [4*COORD_BITS-1:0]             cmd_box,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                pair_valid,
	output logic [aabb_pkg::INDEX_OUT_W-1:0]    first_index,
	output logic [aabb_pkg::INDEX_OUT_W-1:0]    second_index,
	output logic [aabb_pkg::DEPTH_W-1:0]        overlap_depth,
	output logic [1:0]                          contact_side,
	output logic                                boxes_dropped,
	output logic                                run_end
);
	import aabb_pkg::*;

	localparam int IDX_W = $clog2(MAX_BOXES);
	localparam int CNT_W = $clog2(MAX_BOXES + 1);
	localparam int ROW_W = 4 * COORD_BITS;
	localparam int DW    = COORD_BITS + 1;
	localparam int MW    = (DW > DEPTH_W + 1) ? DW : DEPTH_W + 1;

	// absolute value, saturated to the depth width
	function automatic logic [DEPTH_W-1:0] depth_sat(input logic signed [DW-1:0] d);
		logic [DW-1:0] m;
		logic [MW-1:0] w;
		m = d[DW-1] ? unsigned'(-d) : unsigned'(d);
		w = MW'(m);
		depth_sat = (w > MW'(DEPTH_MAX)) ? DEPTH_MAX : w[DEPTH_W-1:0];
	endfunction

	logic [ROW_W-1:0]         store_q [MAX_BOXES];
	logic [ROW_W-1:0]         row_a_q;
	logic [ROW_W-1:0]         row_b_q;
	scan_state_t              state_q;
	scan_state_t              state_d;
	logic [IDX_W-1:0]         i_q;
	logic [IDX_W-1:0]         j_q;
	logic [CNT_W-1:0]         n_q;
	logic                     dropped_q;
	logic                     hit_q;
	logic signed [DW-1:0]     top_q;
	logic signed [DW-1:0]     bot_q;
	logic signed [DW-1:0]     left_q;
	logic signed [DW-1:0]     right_q;
	logic                     hold_valid_q;
	logic [IDX_W-1:0]         hold_i_q;
	logic [IDX_W-1:0]         hold_j_q;
	logic [DEPTH_W-1:0]       hold_depth_q;
	side_t                    hold_side_q;
	logic                     out_valid_q;
	logic                     pair_valid_q;
	logic [INDEX_OUT_W-1:0]   first_q;
	logic [INDEX_OUT_W-1:0]   second_q;
	logic [DEPTH_W-1:0]       depth_q;
	side_t                    side_q;
	logic                     dropped_out_q;
	logic                     run_end_q;

	logic signed [COORD_BITS-1:0] a_min_x, a_min_y, a_max_x, a_max_y;
	logic signed [COORD_BITS-1:0] b_min_x, b_min_y, b_max_x, b_max_y;
	logic [DEPTH_W-1:0]       d_top, d_bot, d_left, d_right;
	logic [DEPTH_W-1:0]       best_depth;
	side_t                    best_side;
	logic                     out_free;
	logic                     last_pair;
	logic                     row_end;
	logic                     pop;
	logic                     start_scan;
	logic                     advance;
	logic                     take_hit;
	logic                     do_flush;

	// corner fields of the two rows under test
	assign a_min_x = row_a_q[4*COORD_BITS-1 -: COORD_BITS];
	assign a_min_y = row_a_q[3*COORD_BITS-1 -: COORD_BITS];
	assign a_max_x = row_a_q[2*COORD_BITS-1 -: COORD_BITS];
	assign a_max_y = row_a_q[COORD_BITS-1 -: COORD_BITS];
	assign b_min_x = row_b_q[4*COORD_BITS-1 -: COORD_BITS];
	assign b_min_y = row_b_q[3*COORD_BITS-1 -: COORD_BITS];
	assign b_max_x = row_b_q[2*COORD_BITS-1 -: COORD_BITS];
	assign b_max_y = row_b_q[COORD_BITS-1 -: COORD_BITS];

	// least penetration, ties kept in top, bottom, left, right order
	always_comb begin
		d_top      = depth_sat(top_q);
		d_bot      = depth_sat(bot_q);
		d_left     = depth_sat(left_q);
		d_right    = depth_sat(right_q);
		best_depth = d_top;
		best_side  = SIDE_TOP;
		if (d_bot < best_depth) begin
			best_depth = d_bot;
			best_side  = SIDE_BOTTOM;
		end
		if (d_left < best_depth) begin
			best_depth = d_left;
			best_side  = SIDE_LEFT;
		end
		if (d_right < best_depth) begin
			best_depth = d_right;
			best_side  = SIDE_RIGHT;
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign row_end   = (CNT_W'(j_q) + CNT_W'(1)) == n_q;
	assign last_pair = row_end && ((CNT_W'(i_q) + CNT_W'(2)) == n_q);
	assign cmd_ready = state_q == ST_IDLE;
	assign pop       = cmd_valid && cmd_ready;

	// sequencer: next state and strobes
	always_comb begin
		state_d    = state_q;
		start_scan = 1'b0;
		advance    = 1'b0;
		take_hit   = 1'b0;
		do_flush   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (pop && cmd_ctl.final_box) begin
					start_scan = 1'b1;
					state_d    = (cmd_count < CNT_W'(2)) ? ST_FLUSH : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				// a second hit can only move on once the output slot frees
				if (!(hit_q && hold_valid_q && !out_free)) begin
					advance  = 1'b1;
					take_hit = hit_q;
					state_d  = last_pair ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					do_flush = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// box store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (pop && cmd_ctl.store) begin
			store_q[cmd_slot] <= cmd_box;
		end
		if (state_q == ST_READ) begin
			row_a_q <= store_q[i_q];
			row_b_q <= store_q[j_q];
		end
	end

	// overlap test and signed penetrations
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			hit_q   <= (a_min_x < b_max_x) && (a_max_x > b_min_x) &&
			           (a_min_y < b_max_y) && (a_max_y > b_min_y);
			top_q   <= DW'(a_max_y) - DW'(b_min_y);
			bot_q   <= DW'(b_max_y) - DW'(a_min_y);
			left_q  <= DW'(b_max_x) - DW'(a_min_x);
			right_q <= DW'(a_max_x) - DW'(b_min_x);
		end
	end

	// pair counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			dropped_q <= 1'b0;
		end else if (start_scan) begin
			i_q       <= '0;
			j_q       <= IDX_W'(1);
			n_q       <= cmd_count;
			dropped_q <= cmd_ctl.dropped;
		end else if (advance && !last_pair) begin
			if (row_end) begin
				i_q <= i_q + IDX_W'(1);
				j_q <= i_q + IDX_W'(2);
			end else begin
				j_q <= j_q + IDX_W'(1);
			end
		end
	end

	// held hit and output register valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((take_hit && hold_valid_q) || do_flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_hit) begin
				hold_valid_q <= 1'b1;
			end else if (do_flush) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	// result payload: the held hit goes out once a later one shows up or the scan ends
	always_ff @(posedge clk) begin
		if (take_hit) begin
			if (hold_valid_q) begin
				pair_valid_q  <= 1'b1;
				first_q       <= INDEX_OUT_W'(hold_i_q);
				second_q      <= INDEX_OUT_W'(hold_j_q);
				depth_q       <= hold_depth_q;
				side_q        <= hold_side_q;
				dropped_out_q <= dropped_q;
				run_end_q     <= 1'b0;
			end
			hold_i_q     <= i_q;
			hold_j_q     <= j_q;
			hold_depth_q <= best_depth;
			hold_side_q  <= best_side;
		end else if (do_flush) begin
			dropped_out_q <= dropped_q;
			run_end_q     <= 1'b1;
			if (hold_valid_q) begin
				pair_valid_q <= 1'b1;
				first_q      <= INDEX_OUT_W'(hold_i_q);
				second_q     <= INDEX_OUT_W'(hold_j_q);
				depth_q      <= hold_depth_q;
				side_q       <= hold_side_q;
			end else begin
				pair_valid_q <= 1'b0;
				first_q      <= '0;
				second_q     <= '0;
				depth_q      <= '0;
				side_q       <= SIDE_TOP;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pair_valid    = pair_valid_q;
	assign first_index   = first_q;
	assign second_index  = second_q;
	assign overlap_depth = depth_q;
	assign contact_side  = side_q;
	assign boxes_dropped = dropped_out_q;
	assign run_end       = run_end_q;

endmodule
